[rtl/core/separation_force_accumulator_assert.svh]
// Assertion helpers shared by the core modules
`ifndef SEPARATION_FORCE_ACCUMULATOR_ASSERT_SVH
`define SEPARATION_FORCE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sfa_pkg.sv]
package sfa_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [30:0] THRESHOLD_RST = 31'd327680;
    localparam logic [30:0] DECAY_RST     = 31'd65536;
    localparam logic [30:0] MAX_PUSH_RST  = 31'd655360;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_DECAY     = 2'd1;
    localparam logic [1:0] REG_MAX_PUSH  = 2'd2;

    // one classified neighbour record
    typedef struct packed {
        logic [2:0][30:0] mag;   // |neighbour - self| per axis
        logic [2:0]       pos;   // axis difference strictly positive
        logic             ok;    // not self and every axis in reach
        logic             first;
        logic             last;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic [2:0][31:0] push;
        logic [15:0]      count;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_CHK,
        S_RUN,
        S_MUL,
        S_DIV,
        S_ACC,
        S_DONE
    } t_state;

endpackage

[rtl/core/sfa_front.sv]
module sfa_front (
    input  logic [31:0]   i_self_x,
    input  logic [31:0]   i_self_y,
    input  logic [31:0]   i_self_z,
    input  logic [63:0]   i_self_id,
    input  logic [31:0]   i_neighbor_x,
    input  logic [31:0]   i_neighbor_y,
    input  logic [31:0]   i_neighbor_z,
    input  logic [63:0]   i_neighbor_id,
    input  logic          i_first_record,
    input  logic          i_last_record,
    output sfa_pkg::t_rec o_rec
);
    import sfa_pkg::*;

    logic [2:0][31:0] self_p;
    logic [2:0][31:0] nb_p;
    logic [2:0][32:0] diff;
    logic [2:0][32:0] mag;
    logic             reach;

    assign self_p = {i_self_z, i_self_y, i_self_x};
    assign nb_p   = {i_neighbor_z, i_neighbor_y, i_neighbor_x};

    always_comb begin
        reach = 1'b1;
        for (int a = 0; a < 3; a++) begin
            diff[a] = {nb_p[a][31], nb_p[a]} - {self_p[a][31], self_p[a]};
            mag[a]  = diff[a][32] ? (33'd0 - diff[a]) : diff[a];
            o_rec.mag[a] = mag[a][30:0];
            o_rec.pos[a] = !diff[a][32] && (diff[a] != 33'd0);
            if (mag[a][32:31] != 2'b00) begin
                reach = 1'b0;
            end
        end
        o_rec.ok    = reach && (i_self_id != i_neighbor_id);
        o_rec.first = i_first_record;
        o_rec.last  = i_last_record;
    end

endmodule

[rtl/core/sfa_queue.sv]
`include "separation_force_accumulator_assert.svh"

module sfa_queue #(
    parameter int DEPTH = sfa_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = sfa_pkg::REC_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import sfa_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [AW:0]      r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wp = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
        end
        if (rd_en) begin
            n_rp = (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + (AW+1)'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `SFA_ASSERT_NOW(a_q_bound, 1'b1, r_cnt <= (AW+1)'(DEPTH), "queue count past depth")
    `SFA_ASSERT_NXT(a_q_inc, wr_en && !rd_en, r_cnt == $past(r_cnt) + (AW+1)'(1), "queue lost a write")
    `SFA_ASSERT_NXT(a_q_dec, rd_en && !wr_en, r_cnt == $past(r_cnt) - (AW+1)'(1), "queue lost a read")

endmodule

[rtl/core/sfa_back.sv]
`include "separation_force_accumulator_assert.svh"

module sfa_back #(
    parameter int FRAC_BITS = sfa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfa_pkg::t_rec i_rec,
    input  logic          i_rec_vld,
    output logic          o_rec_pop,
    input  logic [30:0]   i_threshold,
    input  logic [30:0]   i_decay,
    input  logic [30:0]   i_max_push,
    input  logic          i_pop,
    output sfa_pkg::t_res o_res,
    output logic          o_res_vld
);
    import sfa_pkg::*;

    localparam int SDIV_N = 31 + 2 * FRAC_BITS;   // strength quotient steps
    localparam int CNT_W  = $clog2(SDIV_N + 64);

    t_state r_state, n_state;
    t_rec   r_rec, n_rec;
    logic [2:0]       r_k, n_k;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [61:0] r_prod, n_prod;
    logic [63:0] r_d2, n_d2;
    logic [61:0] r_tt, n_tt;

    // strength divider
    logic [SDIV_N-1:0] r_sdiv, n_sdiv;
    logic [61:0]       r_srem, n_srem;
    logic [31:0]       r_q, n_q;
    logic              r_over, n_over;
    logic [62:0]       s_t;
    logic [31:0]       s_q;
    logic [30:0]       strength;

    // square root
    logic [61:0] r_sq_n, n_sq_n;
    logic [62:0] r_sq_res, n_sq_res;
    logic [62:0] r_sq_bit, n_sq_bit;
    logic [63:0] sq_sum;
    logic [30:0] root_d;

    // per-axis divide lanes: dividend shifts out, quotient shifts in
    logic [2:0][61:0] r_num, n_num;
    logic [2:0][30:0] r_rem, n_rem;
    logic [31:0]      dv_t;

    logic [2:0][31:0] r_sum, n_sum;
    logic [15:0]      r_count, n_count;
    t_res             r_res, n_res;
    logic             r_res_vld, n_res_vld;

    logic [30:0] mul_a, mul_b;
    logic [63:0] push_v, acc_v;

    assign strength = r_over ? i_max_push : r_q[30:0];
    assign root_d   = (r_sq_res[30:0] == '0) ? 31'd1 : r_sq_res[30:0];
    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

    always_comb begin
        mul_a = r_rec.mag[0];
        mul_b = r_rec.mag[0];
        if (r_state == S_SQ) begin
            if (r_k == 3'd1 || r_k == 3'd2) begin
                mul_a = r_rec.mag[r_k[1:0]];
                mul_b = r_rec.mag[r_k[1:0]];
            end else if (r_k == 3'd3) begin
                mul_a = i_threshold;
                mul_b = i_threshold;
            end
        end else begin
            mul_a = strength;
            mul_b = (r_k < 3'd3) ? r_rec.mag[r_k[1:0]] : r_rec.mag[0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_rec     = r_rec;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_prod    = r_prod;
        n_d2      = r_d2;
        n_tt      = r_tt;
        n_sdiv    = r_sdiv;
        n_srem    = r_srem;
        n_q       = r_q;
        n_over    = r_over;
        n_sq_n    = r_sq_n;
        n_sq_res  = r_sq_res;
        n_sq_bit  = r_sq_bit;
        n_num     = r_num;
        n_rem     = r_rem;
        n_sum     = r_sum;
        n_count   = r_count;
        n_res     = r_res;
        n_res_vld = r_res_vld;
        o_rec_pop = 1'b0;
        s_t       = '0;
        s_q       = '0;
        sq_sum    = '0;
        dv_t      = '0;
        push_v    = '0;
        acc_v     = '0;

        if (i_pop && r_res_vld) begin
            n_res_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_rec_vld) begin
                    o_rec_pop = 1'b1;
                    n_rec     = i_rec;
                    n_k       = '0;
                    if (i_rec.first) begin
                        n_sum   = '0;
                        n_count = '0;
                    end
                    n_state = i_rec.ok ? S_SQ : S_DONE;
                end
            end
            S_SQ: begin
                // multiply in step k, fold the previous product in step k+1
                n_prod = 62'(mul_a * mul_b);
                if (r_k == 3'd1) begin
                    n_d2 = {2'b00, r_prod};
                end else if (r_k == 3'd2 || r_k == 3'd3) begin
                    n_d2 = r_d2 + {2'b00, r_prod};
                end else if (r_k == 3'd4) begin
                    n_tt = r_prod;
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd4) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_d2 != '0 && r_d2 < {2'b00, r_tt}) begin
                    n_sdiv   = {i_decay, {(2 * FRAC_BITS){1'b0}}};
                    n_srem   = '0;
                    n_q      = '0;
                    n_over   = 1'b0;
                    n_sq_n   = r_d2[61:0];
                    n_sq_res = '0;
                    n_sq_bit = 63'd1 << 62;
                    n_cnt    = '0;
                    n_state  = S_RUN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RUN: begin
                s_t    = {r_srem, r_sdiv[SDIV_N-1]};
                n_sdiv = {r_sdiv[SDIV_N-2:0], 1'b0};
                if (s_t >= {1'b0, r_d2[61:0]}) begin
                    n_srem = 62'(s_t - {1'b0, r_d2[61:0]});
                    s_q    = {r_q[30:0], 1'b1};
                end else begin
                    n_srem = s_t[61:0];
                    s_q    = {r_q[30:0], 1'b0};
                end
                if (!r_over) begin
                    n_q = s_q;
                    if (s_q > {1'b0, i_max_push}) begin
                        n_over = 1'b1;
                    end
                end
                if (r_cnt < CNT_W'(32)) begin
                    sq_sum = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
                    if ({2'b00, r_sq_n} >= sq_sum) begin
                        n_sq_n   = 62'({2'b00, r_sq_n} - sq_sum);
                        n_sq_res = (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        n_sq_res = r_sq_res >> 1;
                    end
                    n_sq_bit = r_sq_bit >> 2;
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SDIV_N - 1)) begin
                    n_k     = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = 62'(mul_a * mul_b);
                if (r_k != 3'd0) begin
                    n_num[r_k[1:0] - 2'd1] = r_prod;
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd3) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                for (int a = 0; a < 3; a++) begin
                    dv_t = {r_rem[a], r_num[a][61]};
                    if (dv_t >= {1'b0, root_d}) begin
                        n_rem[a] = 31'(dv_t - {1'b0, root_d});
                        n_num[a] = {r_num[a][60:0], 1'b1};
                    end else begin
                        n_rem[a] = dv_t[30:0];
                        n_num[a] = {r_num[a][60:0], 1'b0};
                    end
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(61)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                for (int a = 0; a < 3; a++) begin
                    // push points away from the neighbour
                    push_v = r_rec.pos[a] ? (64'd0 - {2'b00, r_num[a]}) : {2'b00, r_num[a]};
                    acc_v  = {{32{r_sum[a][31]}}, r_sum[a]} + push_v;
                    if ($signed(acc_v) > 64'sh7FFF_FFFF) begin
                        n_sum[a] = 32'h7FFF_FFFF;
                    end else if ($signed(acc_v) < -64'sh8000_0000) begin
                        n_sum[a] = 32'h8000_0000;
                    end else begin
                        n_sum[a] = acc_v[31:0];
                    end
                end
                if (r_count != 16'hFFFF) begin
                    n_count = r_count + 16'd1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_rec.last) begin
                    n_state = S_IDLE;
                end else if (!r_res_vld || i_pop) begin
                    n_res.push  = r_sum;
                    n_res.count = r_count;
                    n_res_vld   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sum     <= '0;
            r_count   <= '0;
            r_res_vld <= 1'b0;
            r_k       <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_count   <= n_count;
            r_res_vld <= n_res_vld;
            r_k       <= n_k;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec    <= n_rec;
        r_prod   <= n_prod;
        r_d2     <= n_d2;
        r_tt     <= n_tt;
        r_sdiv   <= n_sdiv;
        r_srem   <= n_srem;
        r_q      <= n_q;
        r_over   <= n_over;
        r_sq_n   <= n_sq_n;
        r_sq_res <= n_sq_res;
        r_sq_bit <= n_sq_bit;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_res    <= n_res;
    end

    `SFA_ASSERT_NOW(a_cap, r_state == S_MUL, strength <= i_max_push, "strength above cap")
    `SFA_ASSERT_NOW(a_emit, $rose(r_res_vld), $past(r_state) == S_DONE, "result outside done")
    `SFA_ASSERT_NOW(a_acc_ok, r_state == S_ACC, r_rec.ok, "push from skipped item")

endmodule

[rtl/core/separation_force_accumulator.sv]
// The back end works on one item at a time: an item in range runs the squares and compare, the
// bit-serial strength divide (31 + 2*FRAC_BITS steps) beside the square root, the products and
// the 62-step per-axis divide before its push is summed; a self or far-axis item skips all of it,
// one out of range stops after the compare. The queue takes items meanwhile.
// Reset (synchronous, active low) clears sums, count, queue and result; registers reload defaults.
module separation_force_accumulator #(
    parameter int FRAC_BITS   = sfa_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = sfa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_self_x,
    input  logic [31:0] i_self_y,
    input  logic [31:0] i_self_z,
    input  logic [63:0] i_self_id,
    input  logic [31:0] i_neighbor_x,
    input  logic [31:0] i_neighbor_y,
    input  logic [31:0] i_neighbor_z,
    input  logic [63:0] i_neighbor_id,
    input  logic        i_first_record,
    input  logic        i_last_record,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_push_x,
    output logic [31:0] o_push_y,
    output logic [31:0] o_push_z,
    output logic [15:0] o_in_range_count,
    input  logic        valid,
    output logic        ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import sfa_pkg::*;

    t_rec        front_rec;
    t_rec        q_rec;
    logic        q_empty;
    logic        q_pop;
    t_res        res;
    logic        res_vld;
    logic [30:0] r_threshold;
    logic [30:0] r_decay;
    logic [30:0] r_max_push;

    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_decay     <= DECAY_RST;
            r_max_push  <= MAX_PUSH_RST;
        end else if (valid && ready) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_threshold <= i_cfg_data[30:0];
                REG_DECAY:     r_decay     <= i_cfg_data[30:0];
                REG_MAX_PUSH:  r_max_push  <= i_cfg_data[30:0];
                default:       ;
            endcase
        end
    end

    sfa_front u_front (
        .i_self_x       (i_self_x),
        .i_self_y       (i_self_y),
        .i_self_z       (i_self_z),
        .i_self_id      (i_self_id),
        .i_neighbor_x   (i_neighbor_x),
        .i_neighbor_y   (i_neighbor_y),
        .i_neighbor_z   (i_neighbor_z),
        .i_neighbor_id  (i_neighbor_id),
        .i_first_record (i_first_record),
        .i_last_record  (i_last_record),
        .o_rec          (front_rec)
    );

    sfa_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (front_rec),
        .o_full  (full),
        .i_rd    (q_pop),
        .o_data  (q_rec),
        .o_empty (q_empty)
    );

    sfa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (q_rec),
        .i_rec_vld   (!q_empty),
        .o_rec_pop   (q_pop),
        .i_threshold (r_threshold),
        .i_decay     (r_decay),
        .i_max_push  (r_max_push),
        .i_pop       (pop),
        .o_res       (res),
        .o_res_vld   (res_vld)
    );

    assign empty            = !res_vld;
    assign o_push_x         = res.push[0];
    assign o_push_y         = res.push[1];
    assign o_push_z         = res.push[2];
    assign o_in_range_count = res.count;

endmodule

[tb/separation_force_accumulator_checker.sv]
module sfa_push_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [31:0] self_x,
    input  logic [31:0] self_y,
    input  logic [31:0] self_z,
    input  logic [63:0] self_id,
    input  logic [31:0] nbr_x,
    input  logic [31:0] nbr_y,
    input  logic [31:0] nbr_z,
    input  logic [63:0] nbr_id,
    input  logic        first_rec,
    input  logic        last_rec,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] push_x,
    input  logic [31:0] push_y,
    input  logic [31:0] push_z,
    input  logic [15:0] range_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          n_fail,
    output int          n_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfa_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] cnt;
    } push_total_t;

    logic [30:0] thr_q, decay_q, cap_q;
    logic signed [31:0] acc_x, acc_y, acc_z;
    logic [15:0] pushers;
    push_total_t awaited_totals[$];

    assign n_awaited = awaited_totals.size();

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp_add(logic signed [31:0] a, longint b);
        longint s;
        s = longint'(a) + b;
        if (s > 64'sd2147483647) return 32'sh7fffffff;
        if (s < -64'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic longint axis_push(longint unsigned str, longint d,
                                         longint unsigned root_d);
        longint unsigned m;
        m = str * (d < 0 ? -d : d) / root_d;
        return d > 0 ? -longint'(m) : longint'(m);
    endfunction

    task automatic apply_record();
        longint dx, dy, dz;
        longint unsigned ax, ay, az, d2, str, root_d, t;
        logic [127:0] quot;
        push_total_t r;
        dx = longint'($signed(nbr_x)) - longint'($signed(self_x));
        dy = longint'($signed(nbr_y)) - longint'($signed(self_y));
        dz = longint'($signed(nbr_z)) - longint'($signed(self_z));
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        az = dz < 0 ? -dz : dz;
        if (first_rec) begin
            acc_x = 0; acc_y = 0; acc_z = 0; pushers = 0;
        end
        if (nbr_id != self_id && ax < 64'h8000_0000 && ay < 64'h8000_0000
                && az < 64'h8000_0000) begin
            d2 = ax * ax + ay * ay + az * az;
            t = thr_q;
            if (d2 != 0 && d2 < t * t) begin
                quot = (128'(decay_q) << (2 * FB)) / 128'(d2);
                str = (quot > 128'(cap_q)) ? 64'(cap_q) : quot[63:0];
                root_d = int_sqrt(d2);
                if (root_d == 0) root_d = 1;
                acc_x = clamp_add(acc_x, axis_push(str, dx, root_d));
                acc_y = clamp_add(acc_y, axis_push(str, dy, root_d));
                acc_z = clamp_add(acc_z, axis_push(str, dz, root_d));
                if (pushers != 16'hffff) pushers++;
            end
        end
        if (last_rec) begin
            r.x = acc_x; r.y = acc_y; r.z = acc_z; r.cnt = pushers;
            awaited_totals.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        push_total_t e;
        if (!i_rst_n) begin
            thr_q <= THRESHOLD_RST;
            decay_q <= DECAY_RST;
            cap_q <= MAX_PUSH_RST;
            acc_x = 0; acc_y = 0; acc_z = 0; pushers = 0;
            awaited_totals.delete();
            n_fail = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD: thr_q <= cfg_data[30:0];
                    REG_DECAY:     decay_q <= cfg_data[30:0];
                    REG_MAX_PUSH:  cap_q <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (push && !full) apply_record();
            if (pop && !empty) begin
                if (awaited_totals.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result x=%h y=%h z=%h cnt=%0d",
                                 push_x, push_y, push_z, range_count);
                end else begin
                    e = awaited_totals.pop_front();
                    if (e.x !== push_x || e.y !== push_y || e.z !== push_z
                            || e.cnt !== range_count) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("mismatch exp x=%h y=%h z=%h cnt=%0d got x=%h y=%h z=%h cnt=%0d",
                                     e.x, e.y, e.z, e.cnt,
                                     push_x, push_y, push_z, range_count);
                    end
                end
            end
        end
    end
endmodule

[tb/separation_force_accumulator_tb.sv]
module separation_force_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfa_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0, pop = 0, valid = 0;
    logic        full, empty, ready;
    logic [31:0] sx = 0, sy = 0, sz = 0, nx = 0, ny = 0, nz = 0;
    logic [63:0] sid = 0, nid = 0;
    logic        frst = 0, lst = 0;
    logic [31:0] o_px, o_py, o_pz;
    logic [15:0] o_cnt;
    logic [1:0]  cfg_idx = 0;
    logic [31:0] cfg_dat = 0;
    int          n_fail, n_awaited;
    int          idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
    int          hold_left = 0;
    logic [30:0] cur_thr = THRESHOLD_RST;

    always #10 i_clk = ~i_clk;

    separation_force_accumulator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_self_x(sx), .i_self_y(sy), .i_self_z(sz), .i_self_id(sid),
        .i_neighbor_x(nx), .i_neighbor_y(ny), .i_neighbor_z(nz), .i_neighbor_id(nid),
        .i_first_record(frst), .i_last_record(lst), .empty(empty), .pop(pop),
        .o_push_x(o_px), .o_push_y(o_py), .o_push_z(o_pz), .o_in_range_count(o_cnt),
        .valid(valid), .ready(ready), .i_cfg_index(cfg_idx), .i_cfg_data(cfg_dat)
    );

    sfa_push_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .self_x(sx), .self_y(sy), .self_z(sz), .self_id(sid),
        .nbr_x(nx), .nbr_y(ny), .nbr_z(nz), .nbr_id(nid),
        .first_rec(frst), .last_rec(lst), .empty(empty), .pop(pop),
        .push_x(o_px), .push_y(o_py), .push_z(o_pz), .range_count(o_cnt),
        .cfg_valid(valid), .cfg_ready(ready), .cfg_index(cfg_idx), .cfg_data(cfg_dat),
        .n_fail(n_fail), .n_awaited(n_awaited)
    );

    // result side: random stalls per mode, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            case (idle_mode)
                2:       pop <= $urandom_range(99) >= 87;
                3:       pop <= $urandom_range(99) >= 23;
                default: pop <= 1'b1;
            endcase
        end
    end

    task automatic send_record(logic [31:0] ax, ay, az, logic [63:0] aid,
                               logic [31:0] bx, by, bz, logic [63:0] bid,
                               logic f, logic l);
        int pct;
        logic stalled;
        pct = (idle_mode == 1) ? 87 : (idle_mode == 3) ? 23 : 0;
        while ($urandom_range(99) < pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        sx <= ax; sy <= ay; sz <= az; sid <= aid;
        nx <= bx; ny <= by; nz <= bz; nid <= bid;
        frst <= f; lst <= l;
        do begin
            @(negedge i_clk);
            stalled = full;
            @(posedge i_clk);
        end while (stalled);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        logic rdy;
        valid <= 1'b1;
        cfg_idx <= idx;
        cfg_dat <= data;
        do begin
            @(negedge i_clk);
            rdy = ready;
            @(posedge i_clk);
        end while (!rdy);
        valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_THRESHOLD) cur_thr = data[30:0];
    endtask

    // wait out every result, then every record still in flight without a last flag
    task automatic drain();
        push <= 1'b0;
        while (n_awaited != 0) @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    // one agent: a group of records near it, occasionally malformed
    task automatic send_agent(int n_rec, bit broken);
        logic [31:0] ax, ay, az, ox, oy, oz;
        logic [63:0] aid, bid;
        int span, k;
        ax = $urandom_range(32'h7fff_ffff) - 32'h4000_0000;
        ay = $urandom_range(32'h7fff_ffff) - 32'h4000_0000;
        az = $urandom_range(32'h7fff_ffff) - 32'h4000_0000;
        aid = {$urandom, $urandom};
        span = (cur_thr == 0) ? 65536 : (cur_thr > 31'h1000_0000) ? 32'h1000_0000 : cur_thr;
        for (k = 0; k < n_rec; k++) begin
            ox = $urandom_range(2 * span) - span;
            oy = $urandom_range(2 * span) - span;
            oz = $urandom_range(2 * span) - span;
            bid = ($urandom_range(19) == 0) ? aid : {$urandom, $urandom};
            if ($urandom_range(29) == 0) begin
                ox = 0; oy = 0; oz = 0;
            end
            if (broken)
                send_record($urandom, $urandom, $urandom, {$urandom, $urandom},
                            $urandom, $urandom, $urandom, {$urandom, $urandom},
                            $urandom_range(1), $urandom_range(1));
            else
                send_record(ax, ay, az, aid, ax + ox, ay + oy, az + oz, bid,
                            k == 0, k == n_rec - 1);
        end
    endtask

    initial begin
        int ph, sent, n;
        logic [31:0] cfgs[8][3];
        cfgs = '{'{327680, 65536, 655360}, '{0, 65536, 655360},
                 '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
                 '{327680, 0, 655360}, '{327680, 65536, 0},
                 '{32'hffff_ffff, 32'h8000_1000, 32'h0001_0000},
                 '{65536, 32'h7fff_ffff, 32'h7fff_ffff}, '{1310720, 262144, 131072}};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, at reset settings
        send_record(0, 0, 0, 64'd5, 32'h0001_0000, 0, 0, 64'd6, 1, 1);
        send_record(0, 0, 0, 64'd5, 32'h0001_0000, 0, 0, 64'd5, 1, 1);      // self
        send_record(32'h10000, 32'h10000, 0, 1, 32'h10000, 32'h10000, 0, 2, 1, 1); // zero distance
        send_record(32'h8000_0000, 0, 0, 1, 32'h7fff_ffff, 0, 0, 2, 1, 1);   // far axis
        send_record(32'h7fff_ffff, 32'h8000_0000, 0, 64'hffff_ffff_ffff_ffff,
                    32'h7fff_0000, 32'h8000_8000, 32'h0000_4000, 0, 1, 1);
        send_record(0, 0, 0, 1, 32'hffff_f000, 32'h0000_0010, 32'hffff_ffff, 2, 1, 0);
        send_record(0, 0, 0, 1, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 3, 0, 0);
        send_record(0, 0, 0, 1, 32'h0004_ffff, 0, 0, 4, 0, 0);           // just inside
        send_record(0, 0, 0, 1, 32'h0005_0000, 0, 0, 5, 0, 1);           // on threshold
        send_record(0, 0, 0, 1, 0, 0, 32'h0000_0001, 6, 0, 1);           // sums persist
        send_record(0, 0, 0, 1, 0, 32'hffff_0000, 0, 7, 1, 1);
        drain();
        write_reg(2'd3, 32'hffff_ffff);
        write_reg(REG_DECAY, 32'h7fff_ffff);
        write_reg(REG_MAX_PUSH, 32'h7fff_ffff);
        for (n = 0; n < 6; n++)                                           // saturation
            send_record(0, 0, 0, 1, 32'h1, 32'h1, 32'h1, 9, n == 0, n == 5);
        for (n = 0; n < 6; n++)
            send_record(0, 0, 0, 1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 9,
                        n == 0, n == 5);
        drain();

        // random phases, each with a settings row and an idle mode chosen by its index
        sent = 0;
        for (ph = 0; ph < 16; ph++) begin
            idle_mode = ph % 4;
            write_reg(REG_THRESHOLD, cfgs[ph % 8][0]);
            write_reg(REG_DECAY, cfgs[ph % 8][1]);
            write_reg(REG_MAX_PUSH, cfgs[ph % 8][2]);
            if (ph == 4) begin
                // long receiver hold-off while single-record agents keep coming
                hold_left = 3000;
                for (n = 0; n < 30; n++) send_agent(1, 0);
                sent += 30;
            end
            n = 0;
            while (n < 120) begin
                int len;
                len = $urandom_range(8, 1);
                send_agent(len, $urandom_range(9) == 0);
                n += len;
            end
            sent += n;
            drain();
        end

        if (n_fail == 0 && n_awaited == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sfa_pkg.sv
rtl/core/sfa_front.sv
rtl/core/sfa_queue.sv
rtl/core/sfa_back.sv
rtl/core/separation_force_accumulator.sv
tb/separation_force_accumulator_checker.sv
tb/separation_force_accumulator_tb.sv
